@@ hw/rtl/noise_gate_envelope_fsm_macros.svh @@
// Assertion macros used by the noise gate top level.
`ifndef NOISE_GATE_ENVELOPE_FSM_MACROS_SVH
`define NOISE_GATE_ENVELOPE_FSM_MACROS_SVH

// Checks a plain property on every rising clock edge outside of reset.
`define NGATE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define NGATE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define NGATE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ngate_pkg.sv @@
// Package with widths, codes and types shared by the noise gate modules.
package ngate_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_FRAC_W = 23;
	localparam int GAIN_W = GAIN_FRAC_W + 1;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_W;

	localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OPENING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OPEN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSING = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 24'd26527;
	localparam logic [GAIN_W-1:0] ATTACK_RESET = 24'd178956;
	localparam logic [GAIN_W-1:0] DECAY_RESET = 24'd1790;

	typedef struct packed {
		logic [SAMPLE_W-1:0] threshold;
		logic [GAIN_W-1:0] attack;
		logic [GAIN_W-1:0] decay;
	} cfg_t;

endpackage

@@ hw/rtl/ngate_cfg.sv @@
// Configuration registers of the noise gate.
module ngate_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ngate_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ngate_pkg::SAMPLE_W-1:0] cfg_data,
	output ngate_pkg::cfg_t cfg
);

	logic [ngate_pkg::SAMPLE_W-1:0] threshold_q;
	logic [ngate_pkg::GAIN_W-1:0] attack_q;
	logic [ngate_pkg::GAIN_W-1:0] decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ngate_pkg::THRESHOLD_RESET;
			attack_q <= ngate_pkg::ATTACK_RESET;
			decay_q <= ngate_pkg::DECAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ngate_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				ngate_pkg::CFG_ATTACK: attack_q <= ngate_pkg::GAIN_W'(cfg_data);
				ngate_pkg::CFG_DECAY: decay_q <= ngate_pkg::GAIN_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.attack = attack_q;
	assign cfg.decay = decay_q;

endmodule

@@ hw/rtl/ngate_core.sv @@
// Envelope follower and gain state machine of the noise gate.
module ngate_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic signed [ngate_pkg::SAMPLE_W-1:0] sample_s1,
	input  ngate_pkg::cfg_t cfg,
	output logic [ngate_pkg::GAIN_W-1:0] gain_next,
	output logic [ngate_pkg::MODE_W-1:0] mode_next
);

	typedef enum logic [ngate_pkg::MODE_W-1:0] {
		ST_CLOSED = ngate_pkg::MODE_CLOSED,
		ST_OPENING = ngate_pkg::MODE_OPENING,
		ST_OPEN = ngate_pkg::MODE_OPEN,
		ST_CLOSING = ngate_pkg::MODE_CLOSING
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [ngate_pkg::SAMPLE_W-1:0] envelope_q;
	logic [ngate_pkg::SAMPLE_W-1:0] magnitude;
	logic [ngate_pkg::SAMPLE_W-1:0] envelope_d;
	logic [ngate_pkg::GAIN_W-1:0] gain_q;
	logic [ngate_pkg::GAIN_W-1:0] gain_d;
	logic [ngate_pkg::GAIN_W:0] gain_sum;
	logic [ngate_pkg::GAIN_W-1:0] gain_dec;
	logic reached;

	// The negation of the most negative sample wraps to exactly its magnitude.
	assign magnitude = sample_s1[ngate_pkg::SAMPLE_W-1]
		? (~unsigned'(sample_s1) + ngate_pkg::SAMPLE_W'(1)) : unsigned'(sample_s1);
	assign envelope_d = (magnitude > envelope_q) ? magnitude : '0;
	assign reached = envelope_d >= cfg.threshold;
	assign gain_sum = {1'b0, gain_q} + {1'b0, cfg.attack};
	assign gain_dec = (gain_q > cfg.decay) ? (gain_q - cfg.decay) : '0;

	always_comb begin
		state_d = state_q;
		gain_d = gain_q;
		case (state_q)
			ST_CLOSED: begin
				if (reached) state_d = ST_OPENING;
			end
			ST_OPENING: begin
				if (gain_sum >= {1'b0, ngate_pkg::GAIN_UNITY}) begin
					gain_d = ngate_pkg::GAIN_UNITY;
					state_d = ST_OPEN;
				end else begin
					gain_d = ngate_pkg::GAIN_W'(gain_sum);
				end
			end
			ST_OPEN: begin
				if (!reached) state_d = ST_CLOSING;
			end
			ST_CLOSING: begin
				gain_d = gain_dec;
				if (reached) state_d = ST_OPENING;
				else if (gain_dec == '0) state_d = ST_CLOSED;
			end
			default: state_d = ST_CLOSED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLOSED;
			envelope_q <= '0;
			gain_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			envelope_q <= envelope_d;
			gain_q <= gain_d;
		end
	end

	assign gain_next = gain_d;
	assign mode_next = state_d;

endmodule

@@ hw/rtl/noise_gate_envelope_fsm.sv @@
// Top level of the noise gate: config registers, input register, gain core and result register.
// Usage:
// Samples arrive on the sample channel (sample, sample_valid, sample_stall) and
// one result per sample leaves on the result channel (gain, gate_mode,
// result_valid, result_stall). A request is taken at a rising edge where valid
// is high and stall is low.
// A sample taken at an edge is registered in the input register, passes through
// the core, and its gain and mode are registered in the result register.
// Throughput is one sample per cycle while result_stall is low; the envelope,
// gain and mode update is a loop through the core registers, so each sample
// sees the state left by the previous one.
// While the receiver stalls, the result register holds its request and the
// input register holds one more sample; sample_stall rises only when both are
// full. Configuration writes through cfg_we, cfg_index and cfg_data take effect
// at the next edge and are expected only while the block is idle.
// Reset clears the envelope and gain to zero, puts the gate in the closed mode,
// empties both registers and loads the default register values.
`include "noise_gate_envelope_fsm_macros.svh"

module noise_gate_envelope_fsm (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ngate_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ngate_pkg::SAMPLE_W-1:0] cfg_data,
	input  logic signed [ngate_pkg::SAMPLE_W-1:0] sample,
	input  logic sample_valid,
	output logic sample_stall,
	output logic [ngate_pkg::GAIN_W-1:0] gain,
	output logic [ngate_pkg::MODE_W-1:0] gate_mode,
	output logic result_valid,
	input  logic result_stall
);

	ngate_pkg::cfg_t cfg;
	logic signed [ngate_pkg::SAMPLE_W-1:0] sample_s1;
	logic valid_s1;
	logic advance;
	logic accept;
	logic [ngate_pkg::GAIN_W-1:0] gain_next;
	logic [ngate_pkg::MODE_W-1:0] mode_next;
	logic [ngate_pkg::GAIN_W-1:0] gain_q;
	logic [ngate_pkg::MODE_W-1:0] mode_q;
	logic result_valid_q;

	assign advance = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept = sample_valid && !sample_stall;

	ngate_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	ngate_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.sample_s1(sample_s1),
		.cfg(cfg),
		.gain_next(gain_next),
		.mode_next(mode_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) sample_s1 <= sample;
		if (advance) begin
			gain_q <= gain_next;
			mode_q <= mode_next;
		end
	end

	assign gain = gain_q;
	assign gate_mode = mode_q;
	assign result_valid = result_valid_q;

	`NGATE_ASSERT_IMPL(a_gain_le_unity, clk, arst_n, result_valid,
		gain <= ngate_pkg::GAIN_UNITY, "gain above unity")
	`NGATE_ASSERT_IMPL(a_open_at_unity, clk, arst_n,
		result_valid && gate_mode == ngate_pkg::MODE_OPEN,
		gain == ngate_pkg::GAIN_UNITY, "open gate without unity gain")
	`NGATE_ASSERT_IMPL(a_closed_at_zero, clk, arst_n,
		result_valid && gate_mode == ngate_pkg::MODE_CLOSED,
		gain == '0, "closed gate with nonzero gain")
	`NGATE_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, result_valid,
		"result lost after core step")
	`NGATE_ASSERT(a_stall_only_full, clk, arst_n,
		!sample_stall || (valid_s1 && result_valid_q), "input stalled while not full")

endmodule
